[rtl/bacp_pkg.sv]
`default_nettype none
package bacp_pkg;

    localparam int ALIGN_BYTES  = 16;
    localparam int MAX_MARKS    = 16;
    localparam int REGION_BYTES = 2097152;

    localparam int CAP_W   = 22;
    localparam int CNT_W   = 32;
    localparam int REQ_W   = 32;
    localparam int DEPTH_W = $clog2(MAX_MARKS + 1);
    localparam int IDX_W   = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
    localparam int ALIGN_SH = $clog2(ALIGN_BYTES);

    localparam logic [CAP_W-1:0]   REGION_CAP = CAP_W'(REGION_BYTES);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX  = DEPTH_W'(MAX_MARKS);

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RESET   = 2'd1,
        CMD_MARK    = 2'd2,
        CMD_RESTORE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_FULL       = 2'd1,
        ST_STACK_FULL = 2'd2,
        ST_NO_MARK    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_RESP = 2'd2
    } fsm_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } dp_cmd_t;

endpackage
`default_nettype wire

[rtl/bacp_ctrl.sv]
`default_nettype none
module bacp_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bacp_pkg::dp_cmd_t      dp_cmd
);

    bacp_pkg::fsm_t state_reg, state_next;
    logic           m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bacp_pkg::FSM_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bacp_pkg::FSM_IDLE: begin
                if (s_valid) state_next = bacp_pkg::FSM_EXEC;
            end
            bacp_pkg::FSM_EXEC: begin
                state_next = bacp_pkg::FSM_RESP;
            end
            bacp_pkg::FSM_RESP: begin
                if (!m_valid_reg || m_ready) state_next = bacp_pkg::FSM_IDLE;
            end
            default: begin
                state_next = bacp_pkg::FSM_IDLE;
            end
        endcase
    end

    always_comb begin
        dp_cmd.load_in  = (state_reg == bacp_pkg::FSM_IDLE) && s_valid;
        dp_cmd.exec     = (state_reg == bacp_pkg::FSM_EXEC);
        dp_cmd.load_out = (state_reg == bacp_pkg::FSM_RESP) && (!m_valid_reg || m_ready);
        s_ready         = (state_reg == bacp_pkg::FSM_IDLE);
        m_valid_next    = m_valid_reg;
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;
        if (dp_cmd.load_out)        m_valid_next = 1'b1;
    end

    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

[rtl/bacp_dp.sv]
`default_nettype none
module bacp_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bacp_pkg::dp_cmd_t             dp_cmd,
    input  wire logic                          cfg_we,
    input  wire logic [bacp_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [bacp_pkg::REQ_W-1:0]    s_request_bytes,
    output logic [1:0]                         m_status,
    output logic [bacp_pkg::CAP_W-1:0]         m_offset,
    output logic [bacp_pkg::CAP_W-1:0]         m_used_bytes,
    output logic [bacp_pkg::CAP_W-1:0]         m_peak_bytes,
    output logic [bacp_pkg::CAP_W-1:0]         m_remaining_bytes,
    output logic [bacp_pkg::CNT_W-1:0]         m_live_allocs,
    output logic [bacp_pkg::CNT_W-1:0]         m_lifetime_allocs,
    output logic [bacp_pkg::CNT_W-1:0]         m_lifetime_resets,
    output logic [bacp_pkg::DEPTH_W-1:0]       m_stack_depth
);

    localparam int CAP_W   = bacp_pkg::CAP_W;
    localparam int CNT_W   = bacp_pkg::CNT_W;
    localparam int REQ_W   = bacp_pkg::REQ_W;
    localparam int DEPTH_W = bacp_pkg::DEPTH_W;
    localparam int IDX_W   = bacp_pkg::IDX_W;
    localparam int SZ_W    = REQ_W + 1;
    localparam int SUM_W   = SZ_W + 1;

    // command latched at accept
    bacp_pkg::cmd_t          cmd_reg;
    logic [REQ_W-1:0]        req_reg;

    // arena state
    logic [CAP_W-1:0]        cap_reg, cap_next;
    logic [CAP_W-1:0]        fill_reg, fill_next;
    logic [CAP_W-1:0]        peak_reg, peak_next;
    logic [CNT_W-1:0]        live_reg, live_next;
    logic [CNT_W-1:0]        alloc_reg, alloc_next;
    logic [CNT_W-1:0]        resets_reg, resets_next;
    logic [DEPTH_W-1:0]      depth_reg, depth_next;
    logic [CAP_W-1:0]        mark_reg [bacp_pkg::MAX_MARKS];
    bacp_pkg::status_t       status_reg, status_next;
    logic [CAP_W-1:0]        offset_reg, offset_next;

    // result registers
    logic [1:0]              o_status_reg;
    logic [CAP_W-1:0]        o_offset_reg, o_used_reg, o_peak_reg, o_rem_reg;
    logic [CNT_W-1:0]        o_live_reg, o_alloc_reg, o_resets_reg;
    logic [DEPTH_W-1:0]      o_depth_reg;

    logic [SZ_W-1:0]         sz_raw, sz_round;
    logic [SUM_W-1:0]        sum;
    logic                    fits;
    logic [DEPTH_W-1:0]      depth_m1;
    logic                    push;
    logic [CAP_W-1:0]        peak_max;
    logic [CAP_W-1:0]        rem;

    always_comb begin
        cap_next = cfg_wdata;
        if (cfg_wdata > bacp_pkg::REGION_CAP) cap_next = bacp_pkg::REGION_CAP;
    end

    assign sz_raw   = {1'b0, req_reg} + SZ_W'(bacp_pkg::ALIGN_BYTES - 1);
    assign sz_round = (sz_raw >> bacp_pkg::ALIGN_SH) << bacp_pkg::ALIGN_SH;
    assign sum      = SUM_W'(fill_reg) + {1'b0, sz_round};
    assign fits     = (sum <= SUM_W'(cap_reg));
    assign depth_m1 = depth_reg - DEPTH_W'(1);

    always_comb begin
        fill_next   = fill_reg;
        live_next   = live_reg;
        alloc_next  = alloc_reg;
        resets_next = resets_reg;
        depth_next  = depth_reg;
        status_next = bacp_pkg::ST_OK;
        offset_next = '0;
        push        = 1'b0;
        unique case (cmd_reg)
            bacp_pkg::CMD_ALLOC: begin
                if (fits) begin
                    offset_next = fill_reg;
                    fill_next   = sum[CAP_W-1:0];
                    live_next   = live_reg + CNT_W'(1);
                    alloc_next  = alloc_reg + CNT_W'(1);
                end else begin
                    status_next = bacp_pkg::ST_FULL;
                end
            end
            bacp_pkg::CMD_RESET: begin
                fill_next   = '0;
                live_next   = '0;
                depth_next  = '0;
                resets_next = resets_reg + CNT_W'(1);
            end
            bacp_pkg::CMD_MARK: begin
                if (depth_reg >= bacp_pkg::DEPTH_MAX) begin
                    status_next = bacp_pkg::ST_STACK_FULL;
                end else begin
                    push       = 1'b1;
                    depth_next = depth_reg + DEPTH_W'(1);
                end
            end
            bacp_pkg::CMD_RESTORE: begin
                if (depth_reg == '0 || depth_reg > bacp_pkg::DEPTH_MAX) begin
                    status_next = bacp_pkg::ST_NO_MARK;
                end else begin
                    depth_next = depth_m1;
                    fill_next  = mark_reg[depth_m1[IDX_W-1:0]];
                end
            end
            default: begin
                status_next = bacp_pkg::ST_OK;
            end
        endcase
    end

    // peak never drops below fill except right after a grant
    assign peak_max = (fill_reg > peak_reg) ? fill_reg : peak_reg;
    assign peak_next = peak_max;
    assign rem      = (cap_reg > fill_reg) ? (cap_reg - fill_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= bacp_pkg::REGION_CAP;
            fill_reg   <= '0;
            peak_reg   <= '0;
            live_reg   <= '0;
            alloc_reg  <= '0;
            resets_reg <= '0;
            depth_reg  <= '0;
        end else begin
            if (cfg_we) cap_reg <= cap_next;
            if (dp_cmd.exec) begin
                fill_reg   <= fill_next;
                live_reg   <= live_next;
                alloc_reg  <= alloc_next;
                resets_reg <= resets_next;
                depth_reg  <= depth_next;
            end
            if (dp_cmd.load_out) peak_reg <= peak_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.load_in) begin
            cmd_reg <= bacp_pkg::cmd_t'(s_cmd);
            req_reg <= s_request_bytes;
        end
        if (dp_cmd.exec) begin
            status_reg <= status_next;
            offset_reg <= offset_next;
            if (push) mark_reg[depth_reg[IDX_W-1:0]] <= fill_reg;
        end
        if (dp_cmd.load_out) begin
            o_status_reg <= status_reg;
            o_offset_reg <= offset_reg;
            o_used_reg   <= fill_reg;
            o_peak_reg   <= peak_max;
            o_rem_reg    <= rem;
            o_live_reg   <= live_reg;
            o_alloc_reg  <= alloc_reg;
            o_resets_reg <= resets_reg;
            o_depth_reg  <= depth_reg;
        end
    end

    assign m_status          = o_status_reg;
    assign m_offset          = o_offset_reg;
    assign m_used_bytes      = o_used_reg;
    assign m_peak_bytes      = o_peak_reg;
    assign m_remaining_bytes = o_rem_reg;
    assign m_live_allocs     = o_live_reg;
    assign m_lifetime_allocs = o_alloc_reg;
    assign m_lifetime_resets = o_resets_reg;
    assign m_stack_depth     = o_depth_reg;

endmodule
`default_nettype wire

[rtl/bump_allocator_with_checkpoints.sv]
// Channel  | Direction | Handshake          | Beat contents
// s_       | in        | s_valid / s_ready  | cmd, request_bytes
// m_       | out       | m_valid / m_ready  | status, offset, fill, peak, counters
// cfg_     | in        | cfg_valid/cfg_ready| capacity_bytes (22 bits)
//
// Each command is latched, then executed (aligned add and capacity compare,
// stack push/pop, or reset), then loaded into the result register.
// The next command is accepted while the previous result still waits on m_ready;
// a stalled result blocks only the load step of the following command.
// aresetn is synchronous, active low; cfg_ready is always high.
`default_nettype none
module bump_allocator_with_checkpoints (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bacp_pkg::CAP_W-1:0]    cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_cmd,
    input  wire logic [bacp_pkg::REQ_W-1:0]    s_request_bytes,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_status,
    output logic [bacp_pkg::CAP_W-1:0]         m_offset,
    output logic [bacp_pkg::CAP_W-1:0]         m_used_bytes,
    output logic [bacp_pkg::CAP_W-1:0]         m_peak_bytes,
    output logic [bacp_pkg::CAP_W-1:0]         m_remaining_bytes,
    output logic [bacp_pkg::CNT_W-1:0]         m_live_allocs,
    output logic [bacp_pkg::CNT_W-1:0]         m_lifetime_allocs,
    output logic [bacp_pkg::CNT_W-1:0]         m_lifetime_resets,
    output logic [bacp_pkg::DEPTH_W-1:0]       m_stack_depth
);

    bacp_pkg::dp_cmd_t dp_cmd;

    assign cfg_ready = 1'b1;

    bacp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_cmd  (dp_cmd)
    );

    bacp_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .dp_cmd            (dp_cmd),
        .cfg_we            (cfg_valid),
        .cfg_wdata         (cfg_wdata),
        .s_cmd             (s_cmd),
        .s_request_bytes   (s_request_bytes),
        .m_status          (m_status),
        .m_offset          (m_offset),
        .m_used_bytes      (m_used_bytes),
        .m_peak_bytes      (m_peak_bytes),
        .m_remaining_bytes (m_remaining_bytes),
        .m_live_allocs     (m_live_allocs),
        .m_lifetime_allocs (m_lifetime_allocs),
        .m_lifetime_resets (m_lifetime_resets),
        .m_stack_depth     (m_stack_depth)
    );

endmodule
`default_nettype wire

[rtl/bacp_chk.sv]
`default_nettype none
module bacp_chk (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire logic [1:0]                    m_status,
    input  wire logic [bacp_pkg::CAP_W-1:0]    m_offset,
    input  wire logic [bacp_pkg::CAP_W-1:0]    m_used_bytes,
    input  wire logic [bacp_pkg::CAP_W-1:0]    m_peak_bytes,
    input  wire logic [bacp_pkg::CAP_W-1:0]    m_remaining_bytes,
    input  wire logic [bacp_pkg::DEPTH_W-1:0]  m_stack_depth
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_used_bytes) && $stable(m_status))
        else $error("result changed while stalled");

    a_fill_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_used_bytes} + {1'b0, m_remaining_bytes}
                     <= (bacp_pkg::CAP_W + 1)'(bacp_pkg::REGION_BYTES)))
        else $error("fill plus remaining exceeds region");

    a_peak: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_peak_bytes >= m_used_bytes)
        else $error("peak below fill level");

    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_stack_depth <= bacp_pkg::DEPTH_MAX)
        else $error("checkpoint depth out of range");

    a_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != bacp_pkg::ST_OK) |-> m_offset == '0)
        else $error("offset set on failed command");

endmodule

bind bump_allocator_with_checkpoints bacp_chk u_bacp_chk (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_status          (m_status),
    .m_offset          (m_offset),
    .m_used_bytes      (m_used_bytes),
    .m_peak_bytes      (m_peak_bytes),
    .m_remaining_bytes (m_remaining_bytes),
    .m_stack_depth     (m_stack_depth)
);
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

    typedef struct {
        bacp_pkg::cmd_t                 cmd;
        logic [bacp_pkg::REQ_W-1:0]     req;
    } arena_cmd_t;

    typedef struct {
        bacp_pkg::status_t              status;
        logic [bacp_pkg::CAP_W-1:0]     offset;
        logic [bacp_pkg::CAP_W-1:0]     used;
        logic [bacp_pkg::CAP_W-1:0]     peak;
        logic [bacp_pkg::CAP_W-1:0]     remaining;
        logic [bacp_pkg::CNT_W-1:0]     live;
        logic [bacp_pkg::CNT_W-1:0]     lifetime_allocs;
        logic [bacp_pkg::CNT_W-1:0]     lifetime_resets;
        logic [bacp_pkg::DEPTH_W-1:0]   depth;
    } arena_report_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [bacp_pkg::CAP_W-1:0]     cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [1:0]                     s_cmd = bacp_pkg::CMD_ALLOC;
    logic [bacp_pkg::REQ_W-1:0]     s_request_bytes = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [1:0]                     m_status;
    logic [bacp_pkg::CAP_W-1:0]     m_offset;
    logic [bacp_pkg::CAP_W-1:0]     m_used_bytes;
    logic [bacp_pkg::CAP_W-1:0]     m_peak_bytes;
    logic [bacp_pkg::CAP_W-1:0]     m_remaining_bytes;
    logic [bacp_pkg::CNT_W-1:0]     m_live_allocs;
    logic [bacp_pkg::CNT_W-1:0]     m_lifetime_allocs;
    logic [bacp_pkg::CNT_W-1:0]     m_lifetime_resets;
    logic [bacp_pkg::DEPTH_W-1:0]   m_stack_depth;

    bump_allocator_with_checkpoints dut (.*);

    // allocator shadow state
    logic [bacp_pkg::CAP_W-1:0]     arena_cap = bacp_pkg::REGION_CAP;
    logic [bacp_pkg::CAP_W-1:0]     arena_fill = '0;
    logic [bacp_pkg::CAP_W-1:0]     high_water = '0;
    logic [bacp_pkg::CNT_W-1:0]     live_cnt = '0;
    logic [bacp_pkg::CNT_W-1:0]     alloc_cnt = '0;
    logic [bacp_pkg::CNT_W-1:0]     reset_cnt = '0;
    logic [bacp_pkg::DEPTH_W-1:0]   mark_cnt = '0;
    logic [bacp_pkg::CAP_W-1:0]     mark_saved [bacp_pkg::MAX_MARKS];

    arena_cmd_t    cmd_backlog [$];
    arena_report_t report_fifo [$];
    arena_report_t want;

    bit calm = 1'b0;
    int mismatches = 0;
    int queued_total = 0;
    int cfg_writes = 0;
    int cmd_seen [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic arena_report_t apply_command(bacp_pkg::cmd_t c,
                                                    logic [bacp_pkg::REQ_W-1:0] req);
        arena_report_t r;
        logic [63:0]   cap_eff;
        logic [63:0]   rounded;
        cap_eff = (arena_cap > bacp_pkg::REGION_CAP) ? 64'(bacp_pkg::REGION_CAP)
                                                     : 64'(arena_cap);
        r.status = bacp_pkg::ST_OK;
        r.offset = '0;
        case (c)
            bacp_pkg::CMD_ALLOC: begin
                rounded = ((64'(req) + bacp_pkg::ALIGN_BYTES - 1) / bacp_pkg::ALIGN_BYTES)
                          * bacp_pkg::ALIGN_BYTES;
                if (64'(arena_fill) + rounded > cap_eff) begin
                    r.status = bacp_pkg::ST_FULL;
                end else begin
                    r.offset = arena_fill;
                    arena_fill = bacp_pkg::CAP_W'(64'(arena_fill) + rounded);
                    live_cnt = live_cnt + 1;
                    alloc_cnt = alloc_cnt + 1;
                    if (arena_fill > high_water) high_water = arena_fill;
                end
            end
            bacp_pkg::CMD_RESET: begin
                arena_fill = '0;
                live_cnt = '0;
                mark_cnt = '0;
                reset_cnt = reset_cnt + 1;
            end
            bacp_pkg::CMD_MARK: begin
                if (mark_cnt >= bacp_pkg::MAX_MARKS) begin
                    r.status = bacp_pkg::ST_STACK_FULL;
                end else begin
                    mark_saved[mark_cnt] = arena_fill;
                    mark_cnt = mark_cnt + 1;
                end
            end
            default: begin
                if (mark_cnt == 0) begin
                    r.status = bacp_pkg::ST_NO_MARK;
                end else begin
                    mark_cnt = mark_cnt - 1;
                    arena_fill = mark_saved[mark_cnt];
                end
            end
        endcase
        r.used = arena_fill;
        r.peak = high_water;
        r.remaining = (cap_eff > 64'(arena_fill))
                      ? bacp_pkg::CAP_W'(cap_eff - 64'(arena_fill)) : '0;
        r.live = live_cnt;
        r.lifetime_allocs = alloc_cnt;
        r.lifetime_resets = reset_cnt;
        r.depth = mark_cnt;
        return r;
    endfunction

    function automatic void check_field(string name, logic [bacp_pkg::CNT_W-1:0] exp_v,
                                        logic [bacp_pkg::CNT_W-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                report_fifo.push_back(apply_command(bacp_pkg::cmd_t'(s_cmd),
                                                    s_request_bytes));
                cmd_seen[s_cmd]++;
            end
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 14)) begin
                s_cmd <= cmd_backlog[0].cmd;
                s_request_bytes <= cmd_backlog[0].req;
                void'(cmd_backlog.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 14);
        if (aresetn && m_valid && m_ready) begin
            if (report_fifo.size() == 0) begin
                $error("result beat with nothing expected");
                mismatches++;
            end else begin
                want = report_fifo.pop_front();
                status_seen[want.status]++;
                check_field("status", want.status, m_status);
                check_field("offset", want.offset, m_offset);
                check_field("used_bytes", want.used, m_used_bytes);
                check_field("peak_bytes", want.peak, m_peak_bytes);
                check_field("remaining_bytes", want.remaining, m_remaining_bytes);
                check_field("live_allocs", want.live, m_live_allocs);
                check_field("lifetime_allocs", want.lifetime_allocs, m_lifetime_allocs);
                check_field("lifetime_resets", want.lifetime_resets, m_lifetime_resets);
                check_field("stack_depth", want.depth, m_stack_depth);
            end
        end
    end

    task automatic push_cmd(bacp_pkg::cmd_t c, logic [bacp_pkg::REQ_W-1:0] r);
        arena_cmd_t b;
        b.cmd = c;
        b.req = r;
        cmd_backlog.push_back(b);
        queued_total++;
    endtask

    function automatic logic [bacp_pkg::REQ_W-1:0] rand_req(int scale);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) return $urandom_range(0, scale);
        if (pick < 80) begin
            return bacp_pkg::ALIGN_BYTES
                   * $urandom_range(0, scale / bacp_pkg::ALIGN_BYTES);
        end
        if (pick < 92) return $urandom();
        return 32'hFFFF_FFFF - $urandom_range(0, 64);
    endfunction

    function automatic bacp_pkg::cmd_t rand_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return bacp_pkg::CMD_ALLOC;
        if (pick < 58) return bacp_pkg::CMD_RESET;
        if (pick < 78) return bacp_pkg::CMD_MARK;
        return bacp_pkg::CMD_RESTORE;
    endfunction

    // nested checkpoints with allocations between, then unwind as many levels or up to two more
    task automatic queue_nest(int levels, int scale);
        for (int i = 0; i < levels; i++) begin
            push_cmd(bacp_pkg::CMD_MARK, $urandom());
            repeat ($urandom_range(0, 2)) push_cmd(bacp_pkg::CMD_ALLOC, rand_req(scale));
        end
        repeat (levels + $urandom_range(0, 2)) begin
            push_cmd(bacp_pkg::CMD_RESTORE, $urandom());
            if ($urandom_range(0, 3) == 0) push_cmd(bacp_pkg::CMD_ALLOC, rand_req(scale));
        end
    endtask

    task automatic queue_random(int n, int scale);
        int target;
        int pick;
        bacp_pkg::cmd_t c;
        target = queued_total + n;
        while (queued_total < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                repeat ($urandom_range(4, 12)) begin
                    c = rand_cmd();
                    push_cmd(c, (c == bacp_pkg::CMD_ALLOC) ? rand_req(scale) : $urandom());
                end
            end else if (pick < 75) begin
                queue_nest($urandom_range(2, 18), scale);
            end else begin
                repeat ($urandom_range(4, 16)) push_cmd(bacp_pkg::CMD_ALLOC, rand_req(scale));
                push_cmd(($urandom_range(0, 1) == 0) ? bacp_pkg::CMD_RESTORE
                                                     : bacp_pkg::CMD_RESET, $urandom());
            end
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (cmd_backlog.size() != 0 || s_valid || report_fifo.size() != 0);
    endtask

    task automatic write_capacity(logic [bacp_pkg::CAP_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        arena_cap = v;
        cfg_writes++;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_cmd(bacp_pkg::CMD_RESTORE, 32'h0);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd0);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd1);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd15);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd16);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd17);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'hFFFF_FFF1);
        push_cmd(bacp_pkg::CMD_MARK, 32'hFFFF_FFFF);
        push_cmd(bacp_pkg::CMD_ALLOC, bacp_pkg::REGION_BYTES - 80);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd0);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd1);
        push_cmd(bacp_pkg::CMD_RESTORE, 32'h0);
        push_cmd(bacp_pkg::CMD_RESTORE, 32'hFFFF_FFFF);
        push_cmd(bacp_pkg::CMD_RESET, 32'hFFFF_FFFF);
        push_cmd(bacp_pkg::CMD_ALLOC, bacp_pkg::REGION_BYTES);
        push_cmd(bacp_pkg::CMD_ALLOC, bacp_pkg::REGION_BYTES + 1);
        push_cmd(bacp_pkg::CMD_RESET, 32'h0);
        push_cmd(bacp_pkg::CMD_MARK, 32'h0);
        push_cmd(bacp_pkg::CMD_MARK, 32'h5555_AAAA);
        push_cmd(bacp_pkg::CMD_RESET, 32'hAAAA_5555);
        push_cmd(bacp_pkg::CMD_RESTORE, 32'h0);
        push_cmd(bacp_pkg::CMD_ALLOC, bacp_pkg::REGION_BYTES);
        wait_drained();

        queue_random(100, 65536);

        write_capacity(22'h3FFFFF);
        calm = 1'b1;
        queue_random(100, 1 << 17);
        wait_drained();
        calm = 1'b0;

        write_capacity('0);
        queue_nest(17, 32);
        queue_random(60, 32);

        write_capacity(22'd512);
        queue_random(100, 600);

        write_capacity(22'd1000);
        queue_random(80, 300);

        // push the fill level well above a capacity written afterwards
        write_capacity(bacp_pkg::REGION_CAP);
        push_cmd(bacp_pkg::CMD_RESET, 32'h0);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd4096);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd4096);
        push_cmd(bacp_pkg::CMD_MARK, 32'h0);
        push_cmd(bacp_pkg::CMD_ALLOC, 32'd4096);
        write_capacity(22'd48);
        queue_random(80, 64);

        write_capacity(bacp_pkg::REGION_CAP - 1);
        queue_random(80, 200000);

        wait_drained();
        repeat (10) @(posedge aclk);

        $display("covered %0d alloc, %0d reset, %0d checkpoint, %0d restore, %0d cfg writes",
                 cmd_seen[bacp_pkg::CMD_ALLOC], cmd_seen[bacp_pkg::CMD_RESET],
                 cmd_seen[bacp_pkg::CMD_MARK], cmd_seen[bacp_pkg::CMD_RESTORE], cfg_writes);
        $display("statuses: %0d ok, %0d arena full, %0d stack full, %0d nothing to restore",
                 status_seen[bacp_pkg::ST_OK], status_seen[bacp_pkg::ST_FULL],
                 status_seen[bacp_pkg::ST_STACK_FULL], status_seen[bacp_pkg::ST_NO_MARK]);
        if (mismatches == 0 && report_fifo.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
